// ----- rtl/sonar_range_proximity_blinker_unit_assert.svh -----
// assertion macros for the sonar range proximity blinker
`ifndef SONAR_RANGE_PROXIMITY_BLINKER_UNIT_ASSERT_SVH
`define SONAR_RANGE_PROXIMITY_BLINKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SRPB_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("srpb assertion failed");

// next-cycle implication
`define SRPB_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("srpb assertion failed");

`endif

// ----- rtl/srpb_pkg.sv -----
// types and constants shared by the sonar range proximity blinker
package srpb_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int VAL_WIDTH   = 16;
  localparam int CM_CFG_W    = 10;
  localparam int FRAC_BITS   = 10;
  localparam int MUL_A_W     = (COUNT_WIDTH > VAL_WIDTH) ? COUNT_WIDTH : VAL_WIDTH;
  localparam int MUL_B_W     = 10;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MUL_B_W-1:0]   DIST_SCALE_Q10 = MUL_B_W'(878);
  localparam logic [VAL_WIDTH-1:0] SAT_VAL        = '1;

  localparam logic [VAL_WIDTH-1:0] RST_TRIGGER_INTERVAL = VAL_WIDTH'(4000);
  localparam logic [CM_CFG_W-1:0]  RST_NEAR_LIMIT_CM    = CM_CFG_W'(10);
  localparam logic [CM_CFG_W-1:0]  RST_FAR_LIMIT_CM     = CM_CFG_W'(100);
  localparam logic [VAL_WIDTH-1:0] RST_NEAR_HALF_PERIOD = VAL_WIDTH'(2000);
  localparam logic [VAL_WIDTH-1:0] RST_FAR_HALF_PERIOD  = VAL_WIDTH'(20000);
  localparam logic [CM_CFG_W-1:0]  RST_TICKS_PER_CM     = CM_CFG_W'(200);
  localparam logic [VAL_WIDTH-1:0] RST_HALF_PERIOD      = VAL_WIDTH'(20000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_INTERVAL = 3'd0,
    CFG_NEAR_LIMIT_CM    = 3'd1,
    CFG_FAR_LIMIT_CM     = 3'd2,
    CFG_NEAR_HALF_PERIOD = 3'd3,
    CFG_FAR_HALF_PERIOD  = 3'd4,
    CFG_TICKS_PER_CM     = 3'd5
  } srpb_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SCALE,
    ST_FINISH
  } srpb_state_t;

  typedef struct packed {
    logic action;
    logic echo_level;
  } srpb_item_t;

  typedef struct packed {
    logic                 trigger_out;
    logic                 led_out;
    logic [VAL_WIDTH-1:0] distance_cm;
    logic                 distance_new;
  } srpb_result_t;

endpackage

// ----- rtl/srpb_mul.sv -----
// shared multiplier with registered product
module srpb_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [srpb_pkg::MUL_A_W-1:0] a,
  input  logic [srpb_pkg::MUL_B_W-1:0] b,
  output logic [srpb_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= srpb_pkg::PROD_W'(a) * srpb_pkg::PROD_W'(b);
    end
  end

endmodule

// ----- rtl/sonar_range_proximity_blinker_unit.sv -----
// sonar range proximity blinker top level: counters, ranging sequencer, config
// tick and echo-rise items: result valid in the cycle after the item is accepted
// echo-fall items: RANGE, SCALE, then FINISH until the result slot is free; two
// passes through the shared multiplier (distance scale, then half period scale)
// if res_free, ticks and rises pass back to back; falls block items until loaded
// rst is synchronous: counters, led, trigger, sequencer and config to defaults
`include "sonar_range_proximity_blinker_unit_assert.svh"

module sonar_range_proximity_blinker_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  srpb_pkg::srpb_item_t                item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output srpb_pkg::srpb_result_t              result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = srpb_pkg::COUNT_WIDTH;
  localparam int VW = srpb_pkg::VAL_WIDTH;
  localparam int MW = srpb_pkg::MUL_A_W;
  localparam int PW = srpb_pkg::PROD_W;
  localparam int FB = srpb_pkg::FRAC_BITS;
  localparam int KW = srpb_pkg::CM_CFG_W;

  // config registers
  logic [VW-1:0] trigger_interval;
  logic [KW-1:0] near_limit_cm;
  logic [KW-1:0] far_limit_cm;
  logic [VW-1:0] near_half_period;
  logic [VW-1:0] far_half_period;
  logic [KW-1:0] ticks_per_cm;

  // block state
  logic [CW-1:0] trigger_count;
  logic          pulse_pending;
  logic          trigger_level;
  logic [CW-1:0] echo_count;
  logic [VW-1:0] distance_cm;
  logic [VW-1:0] half_period;
  logic [CW-1:0] blink_count;
  logic          led_state;
  logic          near_hit;
  logic          mid_hit;

  srpb_pkg::srpb_state_t state, state_next;

  logic [CW-1:0] trigger_count_next;
  logic          pulse_pending_next;
  logic          trigger_level_next;
  logic [CW-1:0] blink_count_next;
  logic          led_state_next;
  logic [CW-1:0] trigger_inc;
  logic [CW-1:0] blink_inc;

  logic          item_accept;
  logic          res_free;
  logic          is_tick;
  logic          is_rise;
  logic          is_fall;
  logic          mul_en;
  logic          mul_scale;
  logic          finish_load;
  logic [MW-1:0] mul_a;
  logic [srpb_pkg::MUL_B_W-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [MW-1:0] whole_cm;
  logic [VW-1:0] whole_cm_sat;
  logic [VW-1:0] scaled_sat;

  assign cfg_ready   = 1'b1;
  assign res_free    = !result_valid || !result_stall;
  assign item_accept = item_valid && !item_stall;
  assign is_tick     = !item.action;
  assign is_rise     = item.action && item.echo_level;
  assign is_fall     = item.action && !item.echo_level;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      srpb_pkg::ST_IDLE: begin
        if (item_accept && is_fall) state_next = srpb_pkg::ST_RANGE;
      end
      srpb_pkg::ST_RANGE:  state_next = srpb_pkg::ST_SCALE;
      srpb_pkg::ST_SCALE:  state_next = srpb_pkg::ST_FINISH;
      srpb_pkg::ST_FINISH: begin
        if (res_free) state_next = srpb_pkg::ST_IDLE;
      end
      default: state_next = srpb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_stall  = 1'b1;
    mul_en      = 1'b0;
    mul_scale   = 1'b0;
    finish_load = 1'b0;
    unique case (state)
      srpb_pkg::ST_IDLE:   item_stall = !res_free;
      srpb_pkg::ST_RANGE:  mul_en = 1'b1;
      srpb_pkg::ST_SCALE: begin
        mul_en    = 1'b1;
        mul_scale = 1'b1;
      end
      srpb_pkg::ST_FINISH: finish_load = res_free;
      default: item_stall = 1'b1;
    endcase
  end

  // shared multiplier operands
  assign whole_cm = prod[PW-1:FB];
  assign mul_a = mul_scale ? whole_cm : MW'(echo_count);
  assign mul_b = mul_scale ? ticks_per_cm : srpb_pkg::DIST_SCALE_Q10;

  srpb_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign whole_cm_sat = (whole_cm > MW'(srpb_pkg::SAT_VAL)) ? srpb_pkg::SAT_VAL
                                                             : VW'(whole_cm);
  assign scaled_sat   = (prod > PW'(srpb_pkg::SAT_VAL)) ? srpb_pkg::SAT_VAL : VW'(prod);

  // one tick of the trigger and blink counters
  always_comb begin
    trigger_inc        = trigger_count + CW'(1);
    blink_inc          = blink_count + CW'(1);
    trigger_count_next = trigger_inc;
    pulse_pending_next = pulse_pending;
    trigger_level_next = trigger_level;
    blink_count_next   = blink_inc;
    led_state_next     = led_state;
    if (pulse_pending) begin
      trigger_level_next = 1'b0;
      pulse_pending_next = 1'b0;
    end
    if (MW'(trigger_inc) >= MW'(trigger_interval)) begin
      trigger_level_next = 1'b1;
      trigger_count_next = '0;
      pulse_pending_next = 1'b1;
    end
    if (MW'(blink_inc) >= MW'(half_period)) begin
      blink_count_next = '0;
      led_state_next   = !led_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_interval <= srpb_pkg::RST_TRIGGER_INTERVAL;
      near_limit_cm    <= srpb_pkg::RST_NEAR_LIMIT_CM;
      far_limit_cm     <= srpb_pkg::RST_FAR_LIMIT_CM;
      near_half_period <= srpb_pkg::RST_NEAR_HALF_PERIOD;
      far_half_period  <= srpb_pkg::RST_FAR_HALF_PERIOD;
      ticks_per_cm     <= srpb_pkg::RST_TICKS_PER_CM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srpb_pkg::CFG_TRIGGER_INTERVAL: trigger_interval <= cfg_data;
        srpb_pkg::CFG_NEAR_LIMIT_CM:    near_limit_cm    <= cfg_data[KW-1:0];
        srpb_pkg::CFG_FAR_LIMIT_CM:     far_limit_cm     <= cfg_data[KW-1:0];
        srpb_pkg::CFG_NEAR_HALF_PERIOD: near_half_period <= cfg_data;
        srpb_pkg::CFG_FAR_HALF_PERIOD:  far_half_period  <= cfg_data;
        srpb_pkg::CFG_TICKS_PER_CM:     ticks_per_cm     <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srpb_pkg::ST_IDLE;
      trigger_count <= '0;
      pulse_pending <= 1'b0;
      trigger_level <= 1'b0;
      echo_count    <= '0;
      distance_cm   <= '0;
      half_period   <= srpb_pkg::RST_HALF_PERIOD;
      blink_count   <= '0;
      led_state     <= 1'b0;
      result_valid  <= 1'b0;
      near_hit      <= 1'b0;
      mid_hit       <= 1'b0;
    end else begin
      state <= state_next;
      if (item_accept && is_tick) begin
        trigger_count <= trigger_count_next;
        pulse_pending <= pulse_pending_next;
        trigger_level <= trigger_level_next;
        echo_count    <= echo_count + CW'(1);
        blink_count   <= blink_count_next;
        led_state     <= led_state_next;
      end
      if (item_accept && is_rise) begin
        echo_count <= '0;
      end
      // prod holds the distance in q.10 here
      if (state == srpb_pkg::ST_SCALE) begin
        distance_cm <= whole_cm_sat;
        near_hit    <= prod <= PW'({near_limit_cm, FB'(0)});
        mid_hit     <= prod <  PW'({far_limit_cm, FB'(0)});
      end
      if (finish_load) begin
        priority if (near_hit) begin
          half_period <= near_half_period;
        end else if (mid_hit) begin
          half_period <= scaled_sat;
        end else begin
          half_period <= far_half_period;
        end
      end
      if ((item_accept && !is_fall) || finish_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_accept && is_tick) begin
      result.trigger_out  <= trigger_level_next;
      result.led_out      <= led_state_next;
      result.distance_cm  <= distance_cm;
      result.distance_new <= 1'b0;
    end else if (item_accept && is_rise) begin
      result.trigger_out  <= trigger_level;
      result.led_out      <= led_state;
      result.distance_cm  <= distance_cm;
      result.distance_new <= 1'b0;
    end else if (finish_load) begin
      result.trigger_out  <= trigger_level;
      result.led_out      <= led_state;
      result.distance_cm  <= distance_cm;
      result.distance_new <= 1'b1;
    end
  end

  `SRPB_ASSERT_NOW(a_busy_stalls, clk, rst, state != srpb_pkg::ST_IDLE, item_stall)
  `SRPB_ASSERT_NEXT(a_fall_starts_range, clk, rst, item_accept && is_fall, state == srpb_pkg::ST_RANGE)
  `SRPB_ASSERT_NEXT(a_finish_gives_result, clk, rst, finish_load, result_valid && result.distance_new)
  `SRPB_ASSERT_NOW(a_pulse_has_level, clk, rst, pulse_pending, trigger_level)

endmodule

// ----- tb/tb_sonar_range_proximity_blinker_unit.sv -----
// self-checking testbench for the sonar range proximity blinker: queued items, predicted results
module tb_sonar_range_proximity_blinker_unit;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ECHO = 1'b1;
  localparam logic LVL_LOW  = 1'b0;
  localparam logic LVL_HIGH = 1'b1;
  localparam logic [srpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [srpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 80;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  srpb_pkg::srpb_item_t            item = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  srpb_pkg::srpb_result_t          result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [srpb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [srpb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sonar_range_proximity_blinker_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // predictor copy of the configuration
  logic [srpb_pkg::VAL_WIDTH-1:0] cfg_interval;
  logic [srpb_pkg::CM_CFG_W-1:0]  cfg_near_cm;
  logic [srpb_pkg::CM_CFG_W-1:0]  cfg_far_cm;
  logic [srpb_pkg::VAL_WIDTH-1:0] cfg_near_hp;
  logic [srpb_pkg::VAL_WIDTH-1:0] cfg_far_hp;
  logic [srpb_pkg::CM_CFG_W-1:0]  cfg_tpc;

  // predictor copy of the state
  logic [srpb_pkg::COUNT_WIDTH-1:0] trig_cnt;
  logic                             pulse_pend;
  logic                             trig_lvl;
  logic [srpb_pkg::COUNT_WIDTH-1:0] echo_cnt;
  logic [srpb_pkg::VAL_WIDTH-1:0]   echo_width;
  logic [srpb_pkg::VAL_WIDTH-1:0]   blink_half;
  logic [srpb_pkg::COUNT_WIDTH-1:0] blink_cnt;
  logic                             led_lit;

  srpb_pkg::srpb_item_t   pending_items[$];
  srpb_pkg::srpb_result_t due_results[$];
  srpb_pkg::srpb_result_t head;

  int items_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_left = 0;
  int hold_left = 0;
  int n_ranges = 0;
  int n_near = 0;
  int n_mid = 0;
  int n_clip = 0;
  int n_far = 0;
  int n_pulses = 0;
  int n_toggles = 0;
  int cfg_writes = 0;

  function automatic srpb_pkg::srpb_result_t advance_sonar(srpb_pkg::srpb_item_t nxt);
    logic [31:0] q10;
    logic [31:0] span;
    srpb_pkg::srpb_result_t r;
    r.distance_new = 1'b0;
    if (nxt.action == ACT_TICK) begin
      trig_cnt  = trig_cnt + 1'b1;
      echo_cnt  = echo_cnt + 1'b1;
      blink_cnt = blink_cnt + 1'b1;
      if (pulse_pend) begin
        trig_lvl   = 1'b0;
        pulse_pend = 1'b0;
      end
      if (trig_cnt >= cfg_interval) begin
        trig_lvl   = 1'b1;
        trig_cnt   = '0;
        pulse_pend = 1'b1;
        n_pulses++;
      end
      if (blink_cnt >= blink_half) begin
        blink_cnt = '0;
        led_lit   = ~led_lit;
        n_toggles++;
      end
    end else if (nxt.echo_level == LVL_HIGH) begin
      echo_cnt = '0;
    end else begin
      echo_width = echo_cnt;
      q10 = 32'(echo_width) * 32'(srpb_pkg::DIST_SCALE_Q10);
      n_ranges++;
      if (q10 <= (32'(cfg_near_cm) << srpb_pkg::FRAC_BITS)) begin
        blink_half = cfg_near_hp;
        n_near++;
      end else if (q10 < (32'(cfg_far_cm) << srpb_pkg::FRAC_BITS)) begin
        span = 32'(cfg_tpc) * (q10 >> srpb_pkg::FRAC_BITS);
        blink_half = (span > 32'(srpb_pkg::SAT_VAL)) ? srpb_pkg::SAT_VAL
                                                     : span[srpb_pkg::VAL_WIDTH-1:0];
        n_mid++;
        if (span > 32'(srpb_pkg::SAT_VAL)) n_clip++;
      end else begin
        blink_half = cfg_far_hp;
        n_far++;
      end
      r.distance_new = 1'b1;
    end
    q10 = (32'(echo_width) * 32'(srpb_pkg::DIST_SCALE_Q10)) >> srpb_pkg::FRAC_BITS;
    r.trigger_out = trig_lvl;
    r.led_out     = led_lit;
    r.distance_cm = (q10 > 32'(srpb_pkg::SAT_VAL)) ? srpb_pkg::SAT_VAL
                                                   : q10[srpb_pkg::VAL_WIDTH-1:0];
    return r;
  endfunction

  function automatic void push_tick(int n);
    srpb_pkg::srpb_item_t nxt;
    for (int k = 0; k < n; k++) begin
      nxt.action     = ACT_TICK;
      nxt.echo_level = 1'($urandom_range(0, 1));
      pending_items.push_back(nxt);
      items_queued++;
    end
  endfunction

  function automatic void push_echo(logic lvl);
    srpb_pkg::srpb_item_t nxt;
    nxt.action     = ACT_ECHO;
    nxt.echo_level = lvl;
    pending_items.push_back(nxt);
    items_queued++;
  endfunction

  function automatic void push_pulse(int w);
    push_echo(LVL_HIGH);
    push_tick(w);
    push_echo(LVL_LOW);
  endfunction

  // mostly well-formed echo pulses with random widths, plus stray edges and tick runs
  function automatic void queue_traffic(int n, int span);
    int stop;
    int pick;
    stop = items_queued + n;
    while (items_queued < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 7) == 0) begin
          push_tick($urandom_range(0, span));
          push_echo(LVL_LOW);
        end else begin
          push_pulse(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, span));
        end
        push_tick($urandom_range(0, 8));
      end else if (pick == 8) begin
        push_echo(1'($urandom_range(0, 1)));
        push_echo(1'($urandom_range(0, 1)));
      end else begin
        push_tick($urandom_range(1, 30));
      end
    end
  endfunction

  task automatic write_reg(input logic [srpb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srpb_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      srpb_pkg::CFG_TRIGGER_INTERVAL: cfg_interval = val;
      srpb_pkg::CFG_NEAR_LIMIT_CM:    cfg_near_cm  = val[srpb_pkg::CM_CFG_W-1:0];
      srpb_pkg::CFG_FAR_LIMIT_CM:     cfg_far_cm   = val[srpb_pkg::CM_CFG_W-1:0];
      srpb_pkg::CFG_NEAR_HALF_PERIOD: cfg_near_hp  = val;
      srpb_pkg::CFG_FAR_HALF_PERIOD:  cfg_far_hp   = val;
      srpb_pkg::CFG_TICKS_PER_CM:     cfg_tpc      = val[srpb_pkg::CM_CFG_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idle_left = 0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        due_results.push_back(advance_sonar(item));
        items_taken++;
      end
      if (idle_left == 0 && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        idle_left = $urandom_range(1, 19);
      if (idle_left > 0 || pending_items.size() == 0) begin
        if (idle_left > 0) idle_left--;
        item_valid <= 1'b0;
      end else begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          errors++;
        end else begin
          head = due_results.pop_front();
          compare_field("trigger_out", 16'(head.trigger_out), 16'(result.trigger_out));
          compare_field("led_out", 16'(head.led_out), 16'(result.led_out));
          compare_field("distance_cm", head.distance_cm, result.distance_cm);
          compare_field("distance_new", 16'(head.distance_new), 16'(result.distance_new));
        end
        results_seen++;
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        hold_left = $urandom_range(1, 19);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cfg_interval = srpb_pkg::RST_TRIGGER_INTERVAL;
    cfg_near_cm  = srpb_pkg::RST_NEAR_LIMIT_CM;
    cfg_far_cm   = srpb_pkg::RST_FAR_LIMIT_CM;
    cfg_near_hp  = srpb_pkg::RST_NEAR_HALF_PERIOD;
    cfg_far_hp   = srpb_pkg::RST_FAR_HALF_PERIOD;
    cfg_tpc      = srpb_pkg::RST_TICKS_PER_CM;
    trig_cnt     = '0;
    pulse_pend   = 1'b0;
    trig_lvl     = 1'b0;
    echo_cnt     = '0;
    echo_width   = '0;
    blink_half   = srpb_pkg::RST_HALF_PERIOD;
    blink_cnt    = '0;
    led_lit      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: stray fall, short pulse, double rise, zero width
    gap_pct   = 8;
    stall_pct = 8;
    push_tick(2);
    push_echo(LVL_LOW);
    push_pulse(3);
    push_echo(LVL_HIGH);
    push_pulse(0);
    wait_idle();

    // extremes: trigger every tick, zero near half period, clipped middle band
    write_reg(srpb_pkg::CFG_TRIGGER_INTERVAL, 16'd0);
    write_reg(srpb_pkg::CFG_NEAR_LIMIT_CM, 16'd0);
    write_reg(srpb_pkg::CFG_FAR_LIMIT_CM, 16'd1023);
    write_reg(srpb_pkg::CFG_NEAR_HALF_PERIOD, 16'd0);
    write_reg(srpb_pkg::CFG_FAR_HALF_PERIOD, 16'hFFFF);
    write_reg(srpb_pkg::CFG_TICKS_PER_CM, 16'd1023);
    gap_pct   = 3;
    stall_pct = 3;
    push_pulse(2);
    push_tick(3);
    push_pulse(0);
    push_tick(4);
    push_pulse($urandom_range(76, 110));
    push_pulse($urandom_range(76, 110));
    queue_traffic(40, 60);
    wait_idle();

    // other extremes, overlapping limits, oversized values for narrow registers
    write_reg(srpb_pkg::CFG_TRIGGER_INTERVAL, 16'hFFFF);
    write_reg(srpb_pkg::CFG_NEAR_LIMIT_CM, 16'hFFFF);
    write_reg(srpb_pkg::CFG_FAR_LIMIT_CM, 16'hFC00);
    write_reg(srpb_pkg::CFG_NEAR_HALF_PERIOD, 16'd1);
    write_reg(srpb_pkg::CFG_FAR_HALF_PERIOD, 16'd1);
    write_reg(srpb_pkg::CFG_TICKS_PER_CM, 16'h0400);
    gap_pct   = 2;
    stall_pct = 25;
    queue_traffic(50, 30);
    wait_idle();
    queue_traffic(50, 30);
    wait_idle();

    // small bands so all three ranges show up often; spare indexes must do nothing
    write_reg(srpb_pkg::CFG_TRIGGER_INTERVAL, 16'd1);
    write_reg(srpb_pkg::CFG_NEAR_LIMIT_CM, 16'hFC03);
    write_reg(srpb_pkg::CFG_FAR_LIMIT_CM, 16'd20);
    write_reg(srpb_pkg::CFG_NEAR_HALF_PERIOD, 16'd3);
    write_reg(srpb_pkg::CFG_FAR_HALF_PERIOD, 16'd7);
    write_reg(srpb_pkg::CFG_TICKS_PER_CM, 16'd1);
    write_reg(CFG_SPARE_LO, 16'h1234);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    gap_pct   = 20;
    stall_pct = 0;
    queue_traffic(90, 30);
    wait_idle();

    gap_pct   = 6;
    stall_pct = 10;
    repeat (2) begin
      write_reg(srpb_pkg::CFG_TRIGGER_INTERVAL, 16'($urandom_range(1, 40)));
      write_reg(srpb_pkg::CFG_NEAR_LIMIT_CM, 16'($urandom_range(0, 15)));
      write_reg(srpb_pkg::CFG_FAR_LIMIT_CM, 16'($urandom_range(0, 40)));
      write_reg(srpb_pkg::CFG_NEAR_HALF_PERIOD, 16'($urandom_range(0, 12)));
      write_reg(srpb_pkg::CFG_FAR_HALF_PERIOD, 16'($urandom_range(0, 30)));
      write_reg(srpb_pkg::CFG_TICKS_PER_CM, 16'($urandom_range(0, 5)));
      queue_traffic(60, 45);
      wait_idle();
    end

    // closing stretch at full rate
    write_reg(srpb_pkg::CFG_TRIGGER_INTERVAL, 16'd7);
    write_reg(srpb_pkg::CFG_NEAR_LIMIT_CM, 16'd5);
    write_reg(srpb_pkg::CFG_FAR_LIMIT_CM, 16'd25);
    write_reg(srpb_pkg::CFG_NEAR_HALF_PERIOD, 16'd2);
    write_reg(srpb_pkg::CFG_FAR_HALF_PERIOD, 16'd9);
    write_reg(srpb_pkg::CFG_TICKS_PER_CM, 16'd3);
    gap_pct   = 0;
    stall_pct = 0;
    queue_traffic(80, 35);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("run covered %0d items over %0d register writes, %0d trigger pulses, %0d led toggles",
             items_taken, cfg_writes, n_pulses, n_toggles);
    $display("ranges measured %0d: near %0d, middle %0d (clipped %0d), far %0d; errors %0d",
             n_ranges, n_near, n_mid, n_clip, n_far, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
